>>> hdl/stsc_pkg.sv
// shared constants, state codes and helpers for the submatrix sum counter
package stsc_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int DIM_W    = 5;
  localparam int POS_W    = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int ELEM_W   = 16;
  localparam int SUM_W    = 24;
  localparam int CNT_W    = 15;
  localparam int TGT_W    = 32;
  localparam int IDX_W    = 2;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = {CNT_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
  localparam logic [IDX_W-1:0] REG_TARGET_SUM   = 2'd2;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIV    = 4'd1;
  localparam logic [3:0] ST_BINIT  = 4'd2;
  localparam logic [3:0] ST_BRD    = 4'd3;
  localparam logic [3:0] ST_BACC   = 4'd4;
  localparam logic [3:0] ST_PRDB   = 4'd5;
  localparam logic [3:0] ST_PLATB  = 4'd6;
  localparam logic [3:0] ST_PRDA   = 4'd7;
  localparam logic [3:0] ST_PCMP   = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) res = DIM_W'(1);
    else if (v > maxv) res = maxv;
    else res = v;
    return res;
  endfunction

endpackage

>>> hdl/submatrix_target_sum_counter.sv
// submatrix target sum counter: matrix load, band sums and prefix pair search
// load: one element per cycle while not stalled; a config write re-derives load row and column
// search per band (top, bottom): column sums into prefix memory, then every prefix pair a < b
// result in the cycle after the done state that ends the search
// requests stall during config, search and while the result waits; one matrix at a time
// synchronous active-low reset clears control and config; sums and memories keep their values
module submatrix_target_sum_counter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [stsc_pkg::ELEM_W-1:0]     in_element_value,
  input  logic                                   in_last_element,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [stsc_pkg::CNT_W-1:0]             out_match_count,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [stsc_pkg::IDX_W-1:0]             cfg_index,
  input  logic [stsc_pkg::TGT_W-1:0]             cfg_data
);
  import stsc_pkg::*;

  localparam logic [DIM_W-1:0] MAXR = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] MAXC = DIM_W'(MAX_COLS);

  logic [3:0]             state_r, state_nxt;
  logic [DIM_W-1:0]       row_count_r, column_count_r;
  logic [TGT_W-1:0]       target_r;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [DIM_W-1:0]       ld_row_r, ld_row_nxt;
  logic [POS_W-1:0]       ld_col_r, ld_col_nxt;
  logic [DIM_W-1:0]       rows_r, rows_nxt, cols_r, cols_nxt;
  logic [DIM_W-1:0]       top_r, top_nxt, bot_r, bot_nxt;
  logic [DIM_W-1:0]       col_r, col_nxt, a_r, a_nxt, b_r, b_nxt;
  logic signed [SUM_W-1:0] prun_r, prun_nxt, pb_r, pb_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r;
  logic [CNT_W-1:0]       out_cnt_r;

  logic signed [SUM_W-1:0] band_r [MAX_COLS];

  logic signed [ELEM_W-1:0] mat_mem [MAX_ROWS*MAX_COLS];
  logic signed [ELEM_W-1:0] mat_q;
  logic                     mat_we;
  logic [ROW_W+COL_W-1:0]   mat_wa, mat_ra;

  logic signed [SUM_W-1:0] pre_mem [MAX_COLS];
  logic signed [SUM_W-1:0] pre_q;
  logic                    pre_we;
  logic [COL_W-1:0]        pre_wa, pre_ra;
  logic signed [SUM_W-1:0] pre_wd;

  logic [DIM_W-1:0]        cur_rows, cur_cols;
  logic [POS_W-1:0]        total;
  logic [2*DIM_W-1:0]      prod;
  logic                    in_acc, cfg_acc;
  logic signed [SUM_W-1:0] band_new, pa;
  logic [SUM_W:0]          diff;
  logic                    band_we;

  assign cur_rows  = clamp_dim(row_count_r, MAXR);
  assign cur_cols  = clamp_dim(column_count_r, MAXC);
  assign prod      = cur_rows * cur_cols;
  assign total     = prod[POS_W-1:0];
  // a config write takes the cycle, the request waits
  assign in_stall  = (state_r != ST_IDLE) || out_valid_r || cfg_valid;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_valid       = out_valid_r;
  assign out_match_count = out_cnt_r;

  assign band_new = ((top_r == bot_r) ? SUM_W'(0) : band_r[col_r[COL_W-1:0]])
                    + SUM_W'(mat_q);
  assign pa   = (a_r == '0) ? SUM_W'(0) : pre_q;
  assign diff = {pb_r[SUM_W-1], pb_r} - {pa[SUM_W-1], pa};

  // memory ports
  assign mat_we = in_acc && (pos_r < total);
  assign mat_wa = {ld_row_r[ROW_W-1:0], ld_col_r[COL_W-1:0]};
  assign mat_ra = {bot_r[ROW_W-1:0], col_r[COL_W-1:0]};
  assign pre_we = (state_r == ST_BACC);
  assign pre_wa = col_r[COL_W-1:0];
  assign pre_wd = prun_r + band_new;
  assign pre_ra = (state_r == ST_PRDB) ? COL_W'(b_r - DIM_W'(1))
                                       : COL_W'(a_r - DIM_W'(1));
  assign band_we = (state_r == ST_BACC);

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_wa] <= in_element_value;
    end
    mat_q <= mat_mem[mat_ra];
  end

  always_ff @(posedge clk) begin
    if (pre_we) begin
      pre_mem[pre_wa] <= pre_wd;
    end
    pre_q <= pre_mem[pre_ra];
  end

  always_ff @(posedge clk) begin
    if (band_we) begin
      band_r[col_r[COL_W-1:0]] <= band_new;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    ld_row_nxt = ld_row_r;
    ld_col_nxt = ld_col_r;
    rows_nxt   = rows_r;
    cols_nxt   = cols_r;
    top_nxt    = top_r;
    bot_nxt    = bot_r;
    col_nxt    = col_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    prun_nxt   = prun_r;
    pb_nxt     = pb_r;
    cnt_nxt    = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          // re-derive load row and column under the new shape
          state_nxt  = ST_DIV;
          ld_row_nxt = '0;
          ld_col_nxt = pos_r;
        end else if (in_acc) begin
          if (pos_r < total) begin
            pos_nxt = pos_r + POS_W'(1);
            if (ld_col_r + POS_W'(1) == POS_W'(cur_cols)) begin
              ld_col_nxt = '0;
              ld_row_nxt = ld_row_r + DIM_W'(1);
            end else begin
              ld_col_nxt = ld_col_r + POS_W'(1);
            end
          end else begin
            pos_nxt = total;
          end
          if (in_last_element) begin
            rows_nxt  = cur_rows;
            cols_nxt  = cur_cols;
            top_nxt   = '0;
            bot_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_BINIT;
          end
        end
      end
      ST_DIV: begin
        if (pos_r >= total || ld_col_r < POS_W'(cur_cols)) begin
          state_nxt = ST_IDLE;
        end else begin
          ld_col_nxt = ld_col_r - POS_W'(cur_cols);
          ld_row_nxt = ld_row_r + DIM_W'(1);
        end
      end
      ST_BINIT: begin
        col_nxt   = '0;
        prun_nxt  = '0;
        state_nxt = ST_BRD;
      end
      ST_BRD: begin
        state_nxt = ST_BACC;
      end
      ST_BACC: begin
        prun_nxt = pre_wd;
        col_nxt  = col_r + DIM_W'(1);
        if (col_r + DIM_W'(1) == cols_r) begin
          b_nxt     = DIM_W'(1);
          state_nxt = ST_PRDB;
        end else begin
          state_nxt = ST_BRD;
        end
      end
      ST_PRDB: begin
        state_nxt = ST_PLATB;
      end
      ST_PLATB: begin
        pb_nxt    = pre_q;
        a_nxt     = '0;
        state_nxt = ST_PRDA;
      end
      ST_PRDA: begin
        state_nxt = ST_PCMP;
      end
      ST_PCMP: begin
        if ({{(TGT_W-SUM_W-1){diff[SUM_W]}}, diff} == target_r && cnt_r != COUNT_LIMIT) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        a_nxt = a_r + DIM_W'(1);
        if (a_r + DIM_W'(1) == b_r) begin
          if (b_r == cols_r) begin
            // band finished, step bottom row then top row
            if (bot_r + DIM_W'(1) == rows_r) begin
              if (top_r + DIM_W'(1) == rows_r) begin
                state_nxt = ST_DONE;
              end else begin
                top_nxt   = top_r + DIM_W'(1);
                bot_nxt   = top_r + DIM_W'(1);
                state_nxt = ST_BINIT;
              end
            end else begin
              bot_nxt   = bot_r + DIM_W'(1);
              state_nxt = ST_BINIT;
            end
          end else begin
            b_nxt     = b_r + DIM_W'(1);
            state_nxt = ST_PRDB;
          end
        end else begin
          state_nxt = ST_PRDA;
        end
      end
      ST_DONE: begin
        pos_nxt    = '0;
        ld_row_nxt = '0;
        ld_col_nxt = '0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      row_count_r    <= DIM_W'(1);
      column_count_r <= DIM_W'(1);
      target_r       <= '0;
      pos_r          <= '0;
      ld_row_r       <= '0;
      ld_col_r       <= '0;
      rows_r         <= DIM_W'(1);
      cols_r         <= DIM_W'(1);
      top_r          <= '0;
      bot_r          <= '0;
      col_r          <= '0;
      a_r            <= '0;
      b_r            <= '0;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      ld_row_r <= ld_row_nxt;
      ld_col_r <= ld_col_nxt;
      rows_r   <= rows_nxt;
      cols_r   <= cols_nxt;
      top_r    <= top_nxt;
      bot_r    <= bot_nxt;
      col_r    <= col_nxt;
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      cnt_r    <= cnt_nxt;
      if (cfg_acc) begin
        case (cfg_index)
          REG_ROW_COUNT:    row_count_r    <= cfg_data[DIM_W-1:0];
          REG_COLUMN_COUNT: column_count_r <= cfg_data[DIM_W-1:0];
          REG_TARGET_SUM:   target_r       <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_DONE) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prun_r <= prun_nxt;
    pb_r   <= pb_nxt;
    if (state_r == ST_DONE) begin
      out_cnt_r <= cnt_r;
    end
  end

endmodule

>>> test/submatrix_target_sum_counter_tb.sv
// testbench for the submatrix target sum counter: directed and random matrices, scoreboard check
module submatrix_target_sum_counter_tb;
  import stsc_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_PCT = 37;
  localparam int RANDOM_ITEMS = 2000;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_MAX    = 1;
  localparam int FILL_MIN    = 2;
  localparam int FILL_ZERO   = 3;
  localparam int FILL_NARROW = 4;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [ELEM_W-1:0] in_element_value;
  logic                     in_last_element;
  logic                     out_valid;
  logic                     out_stall;
  logic [CNT_W-1:0]         out_match_count;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index;
  logic [TGT_W-1:0]         cfg_data;

  // predictor state
  logic signed [ELEM_W-1:0] elem_store [MAX_ROWS][MAX_COLS];
  bit                       elem_written [MAX_ROWS][MAX_COLS];
  int                       load_pos;
  logic [DIM_W-1:0]         rows_reg;
  logic [DIM_W-1:0]         cols_reg;
  logic signed [TGT_W-1:0]  target_reg;

  logic [CNT_W-1:0] expected_counts [$];
  int  mismatches;
  bit  failed;
  bit  steady;
  int  items_sent;

  submatrix_target_sum_counter DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL submatrix_target_sum_counter");
    $finish;
  end

  function automatic int eff_dim(logic [DIM_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] count_target_sums();
    int rows, cols, n;
    longint band [MAX_COLS];
    longint pre [MAX_COLS+1];
    rows = eff_dim(rows_reg, MAX_ROWS);
    cols = eff_dim(cols_reg, MAX_COLS);
    n = 0;
    for (int top = 0; top < rows; top++) begin
      for (int c = 0; c < cols; c++) band[c] = 0;
      for (int bot = top; bot < rows; bot++) begin
        pre[0] = 0;
        for (int c = 0; c < cols; c++) begin
          band[c] += longint'(elem_store[bot][c]);
          pre[c+1] = pre[c] + band[c];
        end
        for (int b = 1; b <= cols; b++)
          for (int a = 0; a < b; a++)
            if (pre[b] - pre[a] == longint'(target_reg) && n < 32767) n++;
      end
    end
    return CNT_W'(n);
  endfunction

  // advance the predictor by one request, queue the count on the closing element
  task automatic predict_element(logic signed [ELEM_W-1:0] v, bit last);
    int cols, total;
    cols = eff_dim(cols_reg, MAX_COLS);
    total = eff_dim(rows_reg, MAX_ROWS) * cols;
    if (load_pos < total) begin
      elem_store[load_pos / cols][load_pos % cols] = v;
      elem_written[load_pos / cols][load_pos % cols] = 1'b1;
      load_pos++;
    end else begin
      load_pos = total;
    end
    if (last) begin
      expected_counts.push_back(count_target_sums());
      load_pos = 0;
    end
  endtask

  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  task automatic send_element(logic signed [ELEM_W-1:0] v, bit last);
    int gap;
    gap = 0;
    while (idle_now() && gap < 20) gap++;
    predict_element(v, last);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= v;
    in_last_element  <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [TGT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROW_COUNT:    rows_reg = data[DIM_W-1:0];
      REG_COLUMN_COUNT: cols_reg = data[DIM_W-1:0];
      REG_TARGET_SUM:   target_reg = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain(int settle);
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic configure(int rows, int cols, logic [TGT_W-1:0] target);
    drain(20);
    // upper data bits are random: only the low five bits hold a dimension
    write_reg(REG_ROW_COUNT, {27'($urandom), 5'(rows)});
    write_reg(REG_COLUMN_COUNT, {27'($urandom), 5'(cols)});
    write_reg(REG_TARGET_SUM, target);
  endtask

  // a short matrix must only leave positions that hold earlier data
  function automatic bit short_safe(int count);
    int cols, total;
    cols = eff_dim(cols_reg, MAX_COLS);
    total = eff_dim(rows_reg, MAX_ROWS) * cols;
    for (int p = count; p < total; p++)
      if (!elem_written[p / cols][p % cols]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [ELEM_W-1:0] pick_value(int fill);
    case (fill)
      FILL_MAX:    return 16'sh7fff;
      FILL_MIN:    return -16'sh8000;
      FILL_ZERO:   return '0;
      FILL_NARROW: return ELEM_W'($signed($urandom_range(4)) - 2);
      default:     return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic load_matrix(int count, int fill);
    for (int i = 0; i < count; i++)
      send_element(pick_value(fill), i == count - 1);
    end_burst();
  endtask

  task automatic test_reset_defaults();
    // reset shape is 1x1 with target zero
    load_matrix(1, FILL_ZERO);
    send_element(16'sd5, 1'b1);
    end_burst();
  endtask

  task automatic test_extremes();
    configure(2, 2, 32'(4 * 32767));
    load_matrix(4, FILL_MAX);
    configure(2, 2, -32'sd65536);
    load_matrix(4, FILL_MIN);
    configure(2, 2, 32'h8000_0000);
    load_matrix(4, FILL_RANDOM);
    configure(2, 2, 32'h7fff_ffff);
    load_matrix(4, FILL_NARROW);
  endtask

  task automatic test_out_of_range_dims();
    configure(0, 2, 32'sd0);
    write_reg(REG_UNUSED, $urandom);
    load_matrix(2, FILL_NARROW);
    configure(31, 0, 32'sd0);
    load_matrix(16, FILL_NARROW);
  endtask

  task automatic test_short_and_surplus();
    configure(2, 2, 32'sd1);
    load_matrix(2, FILL_NARROW);
    load_matrix(7, FILL_NARROW);
  endtask

  task automatic run_random_matrix();
    int rows, cols, total, count, fill, pick;
    logic [TGT_W-1:0] target;
    if ($urandom_range(49) == 0) begin
      rows = 16;
      cols = 16;
    end else begin
      rows = $urandom_range(5, 1);
      cols = $urandom_range(5, 1);
      if ($urandom_range(19) == 0) rows = $urandom_range(31);
      if ($urandom_range(19) == 0) cols = $urandom_range(31);
    end
    pick = $urandom_range(9);
    fill = (pick < 5) ? FILL_NARROW : (pick < 7) ? FILL_RANDOM :
           (pick == 7) ? FILL_ZERO : (pick == 8) ? FILL_MAX : FILL_MIN;
    pick = $urandom_range(9);
    if (pick < 6) target = 32'($signed($urandom_range(8)) - 4);
    else if (pick < 8) target = $urandom;
    else if (fill == FILL_MAX) target = 32'(32767 * $urandom_range(4, 1));
    else if (fill == FILL_MIN) target = 32'(-32768 * $urandom_range(4, 1));
    else target = '0;
    configure(rows, cols, target);
    total = eff_dim(rows_reg, MAX_ROWS) * eff_dim(cols_reg, MAX_COLS);
    count = total;
    pick = $urandom_range(99);
    if (pick < 8 && total > 1) begin
      count = $urandom_range(total - 1, 1);
      if (!short_safe(count)) count = total;
    end else if (pick < 16) begin
      count = total + $urandom_range(4, 1);
    end
    load_matrix(count, fill);
  endtask

  task automatic test_random();
    while (items_sent < RANDOM_ITEMS) begin
      // one long stretch of full throughput on both sides
      steady = (items_sent > RANDOM_ITEMS / 3) && (items_sent < RANDOM_ITEMS / 2);
      run_random_matrix();
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= idle_now();
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected count %0d with nothing pending", out_match_count);
      end else begin
        logic [CNT_W-1:0] want;
        want = expected_counts.pop_front();
        if (out_match_count !== want) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("match_count mismatch: expected %0d actual %0d", want, out_match_count);
        end
      end
    end
  end

  initial begin
    in_valid = 1'b0;
    in_element_value = '0;
    in_last_element = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ROW_COUNT;
    cfg_data = '0;
    rst_n = 1'b0;
    failed = 1'b0;
    mismatches = 0;
    steady = 1'b0;
    items_sent = 0;
    load_pos = 0;
    rows_reg = 5'd1;
    cols_reg = 5'd1;
    target_reg = '0;
    foreach (elem_store[r, c]) begin
      elem_store[r][c] = '0;
      elem_written[r][c] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_extremes();
    test_out_of_range_dims();
    test_short_and_surplus();
    test_random();

    drain(300);
    if (!failed && expected_counts.size() == 0)
      $display("PASS submatrix_target_sum_counter");
    else
      $display("FAIL submatrix_target_sum_counter");
    $finish;
  end

endmodule
